// ----- design/cws_pkg.sv -----
// shared types, constants and helpers for the comment and whitespace stripper
package cws_pkg;

  localparam int unsigned CWS_SET_SLOTS   = 4;
  localparam int unsigned CWS_REG_W       = 32;
  localparam int unsigned CWS_MAX_SLOTS   = CWS_REG_W / 8;
  localparam int unsigned CWS_ADDR_W      = 4;
  localparam int unsigned CWS_QDEPTH      = 4;
  localparam int unsigned CWS_MAX_RESULTS = 4;

  localparam logic [CWS_REG_W-1:0] CWS_COMMENT_RST = 32'd9019;
  localparam logic [CWS_REG_W-1:0] CWS_QUOTE_RST   = 32'd8743;
  localparam logic [CWS_REG_W-1:0] CWS_KEEP_RST    = 32'd10;

  localparam logic [7:0] CWS_BACKSLASH = 8'h5C;
  localparam logic [7:0] CWS_SLASH     = 8'h2F;
  localparam logic [7:0] CWS_STAR      = 8'h2A;
  localparam logic [7:0] CWS_NEWLINE   = 8'h0A;
  localparam logic [7:0] CWS_SPACE     = 8'h20;

  typedef enum logic [1:0] {
    REG_COMMENT = 2'd0,
    REG_QUOTE   = 2'd1,
    REG_KEEP    = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CWS_REG_W-1:0] comment_bytes;
    logic [CWS_REG_W-1:0] quote_bytes;
    logic [CWS_REG_W-1:0] keep_space_bytes;
  } cfg_t;

  // classified work for the line stage: optional slash, optional byte, end flag
  typedef struct packed {
    logic       a_valid;
    logic       b_valid;
    logic [7:0] b_char;
    logic       last;
  } pkt_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic       lor;
  } result_t;

  function automatic logic in_set(logic [CWS_REG_W-1:0] r, logic [7:0] b,
                                  int unsigned slots);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < CWS_MAX_SLOTS; k++) begin
      if (k < slots && r[8*k +: 8] != 8'd0 && r[8*k +: 8] == b) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ----- design/comment_whitespace_stripper_core.sv -----
// top level of the comment and whitespace stripper
// Text enters one byte per transfer on the in_ channel (in_valid, in_stall,
// in_byte, in_is_last); cleaned bytes leave on the out_ channel (out_valid,
// out_stall, out_byte, out_end_of_text, out_last_of_run). Each input byte
// causes zero to four results; out_last_of_run marks the final one, and the
// byte carrying in_is_last is followed by an end marker with
// out_end_of_text set. The scanner takes one byte per cycle into a
// four-entry packet queue; the line stage pops a packet when idle or as the
// prior one's last result moves out, and delivers one result per cycle
// from its result list through a registered output; throughput is one byte
// per cycle while each byte yields at most one result, otherwise the output
// port, at one result per cycle, sets the pace. A stalled receiver holds
// the output register, the queue fills and in_stall rises once it is full.
// Reset (rst_n low, synchronous) empties the queue, returns the scanner and
// line state to normal text and loads the register defaults.
// Registers sit on an apb-style port at byte addresses 0, 4 and 8.
module comment_whitespace_stripper_core #(
  parameter int unsigned SET_SLOTS = cws_pkg::CWS_SET_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  input  logic                           in_is_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_end_of_text,
  output logic                           out_last_of_run,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cws_pkg::CWS_ADDR_W-1:0] paddr,
  input  logic [cws_pkg::CWS_REG_W-1:0]  pwdata,
  output logic [cws_pkg::CWS_REG_W-1:0]  prdata,
  output logic                           pready
);

  cws_pkg::cfg_t cfg;
  cws_pkg::pkt_t push_data, q_data;
  logic          push, q_full, q_valid, pop;

  cws_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cws_front #(
    .SET_SLOTS (SET_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .in_stall   (in_stall),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .pkt        (push_data)
  );

  cws_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  cws_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ----- design/cws_cfg.sv -----
// configuration registers behind the apb-style port
module cws_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cws_pkg::CWS_ADDR_W-1:0]      paddr,
  input  logic [cws_pkg::CWS_REG_W-1:0]       pwdata,
  output logic [cws_pkg::CWS_REG_W-1:0]       prdata,
  output logic                                pready,
  output cws_pkg::cfg_t                       cfg
);

  cws_pkg::cfg_t    cfg_r;
  cws_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = cws_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.comment_bytes    <= cws_pkg::CWS_COMMENT_RST;
      cfg_r.quote_bytes      <= cws_pkg::CWS_QUOTE_RST;
      cfg_r.keep_space_bytes <= cws_pkg::CWS_KEEP_RST;
    end else if (wr_en) begin
      unique case (idx)
        cws_pkg::REG_COMMENT: cfg_r.comment_bytes    <= pwdata;
        cws_pkg::REG_QUOTE:   cfg_r.quote_bytes      <= pwdata;
        cws_pkg::REG_KEEP:    cfg_r.keep_space_bytes <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cws_pkg::REG_COMMENT: prdata = cfg_r.comment_bytes;
      cws_pkg::REG_QUOTE:   prdata = cfg_r.quote_bytes;
      cws_pkg::REG_KEEP:    prdata = cfg_r.keep_space_bytes;
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- design/cws_front.sv -----
// front scanner: accepts bytes, tracks quotes and comments, emits packets
module cws_front #(
  parameter int unsigned SET_SLOTS = cws_pkg::CWS_SET_SLOTS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_is_last,
  output logic          in_stall,
  input  cws_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          push,
  output cws_pkg::pkt_t pkt
);

  typedef enum logic [2:0] {
    NORMAL     = 3'd0,
    QUOTE      = 3'd1,
    LINE       = 3'd2,
    BLOCK      = 3'd3,
    BLOCK_STAR = 3'd4
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] open_quote_r, open_quote_nxt;
  logic       prior_bs_r, prior_bs_nxt;
  logic       held_slash_r, held_slash_nxt;

  logic fire;
  logic nb_emit, nb_quote, nb_line, nb_slash;
  logic use_nb;

  assign in_stall = q_full;
  assign fire     = in_valid && !in_stall;
  assign push     = fire && (pkt.a_valid || pkt.b_valid || pkt.last);

  // classification of a byte in normal text
  always_comb begin
    nb_emit  = 1'b0;
    nb_quote = 1'b0;
    nb_line  = 1'b0;
    nb_slash = 1'b0;
    if ((in_byte >= 8'h41 && in_byte <= 8'h5A) || (in_byte >= 8'h30 && in_byte <= 8'h39)) begin
      nb_emit = 1'b1;
    end else if (cws_pkg::in_set(cfg.quote_bytes, in_byte, SET_SLOTS)) begin
      nb_emit  = 1'b1;
      nb_quote = 1'b1;
    end else if (cws_pkg::in_set(cfg.comment_bytes, in_byte, SET_SLOTS)) begin
      if (in_byte == cws_pkg::CWS_NEWLINE) nb_emit = 1'b1;
      else nb_line = 1'b1;
    end else if (in_byte == cws_pkg::CWS_SLASH) begin
      nb_slash = 1'b1;
    end else if (in_byte > cws_pkg::CWS_SPACE ||
                 cws_pkg::in_set(cfg.keep_space_bytes, in_byte, SET_SLOTS)) begin
      nb_emit = 1'b1;
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    open_quote_nxt = open_quote_r;
    prior_bs_nxt   = prior_bs_r;
    held_slash_nxt = held_slash_r;
    use_nb         = 1'b0;
    pkt.a_valid    = 1'b0;
    pkt.b_valid    = 1'b0;
    pkt.b_char     = in_byte;
    pkt.last       = in_is_last;

    unique case (mode_r)
      NORMAL: begin
        if (held_slash_r) begin
          held_slash_nxt = 1'b0;
          if (in_byte == cws_pkg::CWS_SLASH) begin
            mode_nxt = LINE;
          end else if (in_byte == cws_pkg::CWS_STAR) begin
            mode_nxt = BLOCK;
          end else begin
            pkt.a_valid = 1'b1;
            use_nb      = 1'b1;
          end
        end else begin
          use_nb = 1'b1;
        end
      end
      QUOTE: begin
        pkt.b_valid = 1'b1;
        if (in_byte == open_quote_r && !prior_bs_r) begin
          mode_nxt     = NORMAL;
          prior_bs_nxt = 1'b0;
        end else begin
          prior_bs_nxt = (in_byte == cws_pkg::CWS_BACKSLASH);
        end
      end
      LINE: begin
        if (in_byte == cws_pkg::CWS_NEWLINE) begin
          pkt.b_valid = 1'b1;
          mode_nxt    = NORMAL;
        end
      end
      BLOCK: begin
        if (in_byte == cws_pkg::CWS_STAR) mode_nxt = BLOCK_STAR;
      end
      BLOCK_STAR: begin
        if (in_byte == cws_pkg::CWS_SLASH) mode_nxt = NORMAL;
        else if (in_byte != cws_pkg::CWS_STAR) mode_nxt = BLOCK;
      end
      default: mode_nxt = NORMAL;
    endcase

    if (use_nb) begin
      pkt.b_valid    = nb_emit;
      held_slash_nxt = nb_slash;
      if (nb_quote) begin
        open_quote_nxt = in_byte;
        prior_bs_nxt   = (in_byte == cws_pkg::CWS_BACKSLASH);
        mode_nxt       = QUOTE;
      end
      if (nb_line) mode_nxt = LINE;
    end

    if (in_is_last) begin
      // flush a pending slash at end of text
      if (held_slash_nxt && mode_nxt == NORMAL) begin
        pkt.b_valid = 1'b1;
        pkt.b_char  = cws_pkg::CWS_SLASH;
      end
      mode_nxt       = NORMAL;
      open_quote_nxt = 8'd0;
      prior_bs_nxt   = 1'b0;
      held_slash_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= NORMAL;
      open_quote_r <= 8'd0;
      prior_bs_r   <= 1'b0;
      held_slash_r <= 1'b0;
    end else if (fire) begin
      mode_r       <= mode_nxt;
      open_quote_r <= open_quote_nxt;
      prior_bs_r   <= prior_bs_nxt;
      held_slash_r <= held_slash_nxt;
    end
  end

  a_slash_only_normal: assert property (@(posedge clk) disable iff (!rst_n)
    held_slash_r |-> mode_r == NORMAL)
    else $error("held slash outside normal text");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_is_last) |=> (mode_r == NORMAL && !held_slash_r && !prior_bs_r))
    else $error("scanner state not cleared after end of text");

endmodule

// ----- design/cws_queue.sv -----
// short packet queue between scanner and line stage
module cws_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cws_pkg::pkt_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output cws_pkg::pkt_t q_data
);

  localparam int unsigned PTR_W = $clog2(cws_pkg::CWS_QDEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  cws_pkg::pkt_t    slot_r [cws_pkg::CWS_QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(cws_pkg::CWS_QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = slot_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !do_pop) count_r <= count_r + CNT_W'(1);
      else if (do_pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(cws_pkg::CWS_QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

endmodule

// ----- design/cws_back.sv -----
// line stage: drops empty lines and trailing newline, serializes results
module cws_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  cws_pkg::pkt_t q_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_end_of_text,
  output logic          out_last_of_run
);

  localparam int unsigned CNT_W = $clog2(cws_pkg::CWS_MAX_RESULTS) + 1;
  localparam int unsigned IDX_W = $clog2(cws_pkg::CWS_MAX_RESULTS);

  cws_pkg::result_t [cws_pkg::CWS_MAX_RESULTS-1:0] list_r, ent;
  logic [CNT_W-1:0] cnt_r, n;
  logic             nl_held_r, nl_held_nxt;
  logic             nonempty_r, nonempty_nxt;
  cws_pkg::result_t out_r;
  logic             out_valid_r;
  logic             out_load, move;

  assign out_load = !out_valid_r || !out_stall;
  assign move     = (cnt_r != '0) && out_load;
  assign pop      = q_valid && ((cnt_r == '0) || (cnt_r == CNT_W'(1) && move));

  assign out_valid       = out_valid_r;
  assign out_byte        = out_r.data;
  assign out_end_of_text = out_r.eot;
  assign out_last_of_run = out_r.lor;

  // expand one packet into its results
  always_comb begin
    ent          = '0;
    n            = '0;
    nl_held_nxt  = nl_held_r;
    nonempty_nxt = nonempty_r;
    if (q_data.a_valid) begin
      if (nl_held_nxt) begin
        ent[n[IDX_W-1:0]].data = cws_pkg::CWS_NEWLINE;
        n = n + CNT_W'(1);
      end
      ent[n[IDX_W-1:0]].data = cws_pkg::CWS_SLASH;
      n = n + CNT_W'(1);
      nl_held_nxt  = 1'b0;
      nonempty_nxt = 1'b1;
    end
    if (q_data.b_valid) begin
      if (q_data.b_char == cws_pkg::CWS_NEWLINE) begin
        if (nonempty_nxt) begin
          nl_held_nxt  = 1'b1;
          nonempty_nxt = 1'b0;
        end
      end else begin
        if (nl_held_nxt) begin
          ent[n[IDX_W-1:0]].data = cws_pkg::CWS_NEWLINE;
          n = n + CNT_W'(1);
        end
        ent[n[IDX_W-1:0]].data = q_data.b_char;
        n = n + CNT_W'(1);
        nl_held_nxt  = 1'b0;
        nonempty_nxt = 1'b1;
      end
    end
    if (q_data.last) begin
      ent[n[IDX_W-1:0]].eot = 1'b1;
      n = n + CNT_W'(1);
      nl_held_nxt  = 1'b0;
      nonempty_nxt = 1'b0;
    end
    if (n != '0) ent[n[IDX_W-1:0] - IDX_W'(1)].lor = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      nl_held_r   <= 1'b0;
      nonempty_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cnt_r      <= n;
        nl_held_r  <= nl_held_nxt;
        nonempty_r <= nonempty_nxt;
      end else if (move) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (out_load) out_valid_r <= move;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) list_r <= ent;
    else if (move) list_r <= {{$bits(cws_pkg::result_t){1'b0}},
                              list_r[cws_pkg::CWS_MAX_RESULTS-1:1]};
    if (move) out_r <= list_r[0];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(cws_pkg::CWS_MAX_RESULTS))
    else $error("result count beyond limit");

  a_eot_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.eot) |-> out_r.lor)
    else $error("end marker not last of run");

endmodule

// ----- test/comment_whitespace_stripper_core_tb.sv -----
// self-checking testbench for the comment and whitespace stripper core
`timescale 1ns / 100ps

typedef enum logic [2:0] {
  SCAN_NORMAL,
  SCAN_QUOTE,
  SCAN_LINE,
  SCAN_BLOCK,
  SCAN_BLOCK_STAR
} scan_state_t;

class strip_checker;
  logic [cws_pkg::CWS_REG_W-1:0] comment_set;
  logic [cws_pkg::CWS_REG_W-1:0] quote_set;
  logic [cws_pkg::CWS_REG_W-1:0] keep_set;

  scan_state_t mode;
  logic [7:0]  open_q;
  bit          prev_bs;
  bit          slash_held;
  bit          nl_held;
  bit          line_has_text;

  cws_pkg::result_t cleaned_q[$];
  cws_pkg::result_t run_q[$];
  int               errors;

  function new();
    comment_set = cws_pkg::CWS_COMMENT_RST;
    quote_set   = cws_pkg::CWS_QUOTE_RST;
    keep_set    = cws_pkg::CWS_KEEP_RST;
    errors      = 0;
    clear_text();
  endfunction

  function void clear_text();
    mode          = SCAN_NORMAL;
    open_q        = 8'd0;
    prev_bs       = 1'b0;
    slash_held    = 1'b0;
    nl_held       = 1'b0;
    line_has_text = 1'b0;
  endfunction

  function void set_reg(cws_pkg::reg_idx_t idx, logic [cws_pkg::CWS_REG_W-1:0] v);
    case (idx)
      cws_pkg::REG_COMMENT: comment_set = v;
      cws_pkg::REG_QUOTE:   quote_set = v;
      cws_pkg::REG_KEEP:    keep_set = v;
      default: ;
    endcase
  endfunction

  function bit member(logic [cws_pkg::CWS_REG_W-1:0] r, logic [7:0] c);
    for (int k = 0; k < cws_pkg::CWS_SET_SLOTS; k++) begin
      if (r[8*k +: 8] != 8'd0 && r[8*k +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void emit(logic [7:0] c, logic eot);
    cws_pkg::result_t r;
    r.data = c;
    r.eot  = eot;
    r.lor  = 1'b0;
    if (run_q.size() < cws_pkg::CWS_MAX_RESULTS) run_q.push_back(r);
  endfunction

  // line stage: empty lines and the trailing newline vanish
  function void line_out(logic [7:0] c);
    if (c == cws_pkg::CWS_NEWLINE) begin
      if (line_has_text) begin
        nl_held       = 1'b1;
        line_has_text = 1'b0;
      end
    end else begin
      if (nl_held) begin
        emit(cws_pkg::CWS_NEWLINE, 1'b0);
        nl_held = 1'b0;
      end
      emit(c, 1'b0);
      line_has_text = 1'b1;
    end
  endfunction

  function void plain_char(logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39)) begin
      line_out(c);
    end else if (member(quote_set, c)) begin
      line_out(c);
      open_q  = c;
      prev_bs = (c == cws_pkg::CWS_BACKSLASH);
      mode    = SCAN_QUOTE;
    end else if (member(comment_set, c)) begin
      if (c == cws_pkg::CWS_NEWLINE) line_out(c);
      else mode = SCAN_LINE;
    end else if (c == cws_pkg::CWS_SLASH) begin
      slash_held = 1'b1;
    end else if (c > cws_pkg::CWS_SPACE || member(keep_set, c)) begin
      line_out(c);
    end
  endfunction

  function void take_source_byte(logic [7:0] c, logic last);
    run_q.delete();
    case (mode)
      SCAN_NORMAL: begin
        if (slash_held) begin
          slash_held = 1'b0;
          if (c == cws_pkg::CWS_SLASH) mode = SCAN_LINE;
          else if (c == cws_pkg::CWS_STAR) mode = SCAN_BLOCK;
          else begin
            line_out(cws_pkg::CWS_SLASH);
            plain_char(c);
          end
        end else begin
          plain_char(c);
        end
      end
      SCAN_QUOTE: begin
        line_out(c);
        if (c == open_q && !prev_bs) begin
          mode    = SCAN_NORMAL;
          prev_bs = 1'b0;
        end else begin
          prev_bs = (c == cws_pkg::CWS_BACKSLASH);
        end
      end
      SCAN_LINE: begin
        if (c == cws_pkg::CWS_NEWLINE) begin
          line_out(c);
          mode = SCAN_NORMAL;
        end
      end
      SCAN_BLOCK: begin
        if (c == cws_pkg::CWS_STAR) mode = SCAN_BLOCK_STAR;
      end
      SCAN_BLOCK_STAR: begin
        if (c == cws_pkg::CWS_SLASH) mode = SCAN_NORMAL;
        else if (c != cws_pkg::CWS_STAR) mode = SCAN_BLOCK;
      end
      default: mode = SCAN_NORMAL;
    endcase
    if (last) begin
      if (slash_held && mode == SCAN_NORMAL) begin
        slash_held = 1'b0;
        line_out(cws_pkg::CWS_SLASH);
      end
      emit(8'd0, 1'b1);
      clear_text();
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].lor = 1'b1;
    foreach (run_q[i]) cleaned_q.push_back(run_q[i]);
  endfunction

  function void check_cleaned(logic [7:0] c, logic eot, logic lor);
    cws_pkg::result_t want;
    if (cleaned_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual byte %h eot %b lor %b",
               $time, c, eot, lor);
      errors++;
    end else begin
      want = cleaned_q.pop_front();
      if (want.eot != eot) begin
        $display("%0t: end_of_text expected %b actual %b", $time, want.eot, eot);
        errors++;
      end
      // the byte field carries no meaning on an end marker
      if (!want.eot && want.data != c) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.data, c);
        errors++;
      end
      if (want.lor != lor) begin
        $display("%0t: last_of_run expected %b actual %b", $time, want.lor, lor);
        errors++;
      end
    end
  endfunction

  function int waiting();
    return cleaned_q.size();
  endfunction
endclass

module comment_whitespace_stripper_core_tb;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_byte = 8'd0;
  logic                           in_is_last = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     out_byte;
  logic                           out_end_of_text;
  logic                           out_last_of_run;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [cws_pkg::CWS_ADDR_W-1:0] paddr = '0;
  logic [cws_pkg::CWS_REG_W-1:0]  pwdata = '0;
  logic [cws_pkg::CWS_REG_W-1:0]  prdata;
  logic                           pready;

  strip_checker sb = new();
  logic [7:0]   text_q[$];
  bit           idle_on = 1'b1;
  int           stall_left = 0;
  int           items = 0;
  int           idle_cycles = 0;

  comment_whitespace_stripper_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_end_of_text(out_end_of_text), .out_last_of_run(out_last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  task automatic send_char(logic [7:0] c, logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= c;
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_source_byte(c, last);
    items++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // hold off the sender until every expected result is out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cws_pkg::reg_idx_t idx, logic [cws_pkg::CWS_REG_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] alnum();
    case ($urandom_range(0, 2))
      0: return 8'h41 + 8'($urandom_range(0, 25));
      1: return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] set_char();
    case ($urandom_range(0, 11))
      0: return 8'h3B;
      1: return 8'h23;
      2: return 8'h22;
      3: return 8'h27;
      4: return cws_pkg::CWS_BACKSLASH;
      5: return cws_pkg::CWS_NEWLINE;
      6: return cws_pkg::CWS_SLASH;
      7: return cws_pkg::CWS_STAR;
      8: return cws_pkg::CWS_SPACE;
      9: return 8'h09;
      10: return 8'h00;
      default: return rand_byte();
    endcase
  endfunction

  function automatic logic [7:0] pick_slot(logic [cws_pkg::CWS_REG_W-1:0] r,
                                           logic [7:0] dflt);
    logic [7:0] c;
    c = r[8*$urandom_range(0, 3) +: 8];
    return (c == 8'd0) ? dflt : c;
  endfunction

  // random text made of well-formed tokens with some noise mixed in
  function automatic void build_text();
    int         goal;
    int         n;
    logic [7:0] q;
    text_q.delete();
    goal = $urandom_range(1, 30);
    while (text_q.size() < goal) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 5);
          repeat (n) text_q.push_back(alnum());
        end
        2: begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            case ($urandom_range(0, 5))
              0: text_q.push_back(cws_pkg::CWS_SPACE);
              1: text_q.push_back(8'h09);
              2: text_q.push_back(cws_pkg::CWS_NEWLINE);
              3: text_q.push_back(8'h0D);
              4: text_q.push_back(8'h00);
              default: text_q.push_back(pick_slot(sb.keep_set, cws_pkg::CWS_SPACE));
            endcase
          end
        end
        3: begin
          q = pick_slot(sb.quote_set, 8'h22);
          text_q.push_back(q);
          n = $urandom_range(0, 6);
          repeat (n) begin
            case ($urandom_range(0, 4))
              0: text_q.push_back(alnum());
              1: text_q.push_back(cws_pkg::CWS_BACKSLASH);
              2: text_q.push_back(q);
              3: text_q.push_back($urandom_range(0, 1) ? cws_pkg::CWS_SPACE
                                                       : cws_pkg::CWS_NEWLINE);
              default: text_q.push_back(rand_byte());
            endcase
          end
          text_q.push_back(q);
        end
        4: begin
          q = pick_slot(sb.comment_set, 8'h00);
          if (q == 8'h00 || $urandom_range(0, 2) == 0) begin
            text_q.push_back(cws_pkg::CWS_SLASH);
            text_q.push_back(cws_pkg::CWS_SLASH);
          end else begin
            text_q.push_back(q);
          end
          n = $urandom_range(0, 5);
          repeat (n) text_q.push_back($urandom_range(0, 1) ? alnum() : rand_byte());
          text_q.push_back(cws_pkg::CWS_NEWLINE);
        end
        5: begin
          text_q.push_back(cws_pkg::CWS_SLASH);
          text_q.push_back(cws_pkg::CWS_STAR);
          n = $urandom_range(0, 6);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0: text_q.push_back(cws_pkg::CWS_STAR);
              1: text_q.push_back(cws_pkg::CWS_SLASH);
              2: text_q.push_back(alnum());
              default: text_q.push_back(cws_pkg::CWS_NEWLINE);
            endcase
          end
          text_q.push_back(cws_pkg::CWS_STAR);
          text_q.push_back(cws_pkg::CWS_SLASH);
        end
        6: text_q.push_back(cws_pkg::CWS_SLASH);
        7: begin
          n = $urandom_range(1, 3);
          repeat (n) text_q.push_back(rand_byte());
        end
        8: begin
          n = $urandom_range(1, 3);
          repeat (n) text_q.push_back(cws_pkg::CWS_NEWLINE);
        end
        default: text_q.push_back(set_char());
      endcase
    end
  endfunction

  // result monitor and receiver stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_cleaned(out_byte, out_end_of_text, out_last_of_run);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_text("Z0 \"a\\\"/\"\n\n;c\n");
    send_text("a//b\n/*\n*/q/");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);

    for (int p = 0; p < 7; p++) begin
      drain();
      case (p)
        0: ;
        1: begin
          write_reg(cws_pkg::REG_COMMENT, 32'h0000_0000);
          write_reg(cws_pkg::REG_QUOTE, 32'h0000_0000);
          write_reg(cws_pkg::REG_KEEP, 32'h0000_0000);
        end
        2: begin
          write_reg(cws_pkg::REG_COMMENT, 32'hFFFF_FFFF);
          write_reg(cws_pkg::REG_QUOTE, 32'hFFFF_FFFF);
          write_reg(cws_pkg::REG_KEEP, 32'hFFFF_FFFF);
        end
        3: begin
          // newline in the comment set, backslash as a quote
          write_reg(cws_pkg::REG_COMMENT,
                    {set_char(), set_char(), set_char(), cws_pkg::CWS_NEWLINE});
          write_reg(cws_pkg::REG_QUOTE,
                    {set_char(), set_char(), set_char(), cws_pkg::CWS_BACKSLASH});
          write_reg(cws_pkg::REG_KEEP, {set_char(), set_char(), set_char(), set_char()});
        end
        6: begin
          idle_on = 1'b0;
          write_reg(cws_pkg::REG_COMMENT, cws_pkg::CWS_COMMENT_RST);
          write_reg(cws_pkg::REG_QUOTE, cws_pkg::CWS_QUOTE_RST);
          write_reg(cws_pkg::REG_KEEP, cws_pkg::CWS_KEEP_RST);
        end
        default: begin
          write_reg(cws_pkg::REG_COMMENT, {set_char(), set_char(), set_char(), set_char()});
          write_reg(cws_pkg::REG_QUOTE, {set_char(), set_char(), set_char(), set_char()});
          write_reg(cws_pkg::REG_KEEP, {set_char(), set_char(), set_char(), set_char()});
        end
      endcase
      goal = 28 + (p + 1) * 49;
      while (items < goal) begin
        build_text();
        foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
        if (idle_on && $urandom_range(0, 7) == 0) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
